FILE: rtl/core/lpg_pkg.sv
// shared types and constants of the permutation generator
`timescale 1ns / 1ps
`default_nettype none

package lpg_pkg;

	localparam int LPG_MAX_LENGTH = 8;
	localparam int LPG_LEN_W      = 4;
	localparam int LPG_VAL_W      = 4;
	localparam int LPG_TDATA_W    = 8;
	localparam logic [LPG_LEN_W-1:0] LPG_LEN_RESET = 4'd3;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_P_RD,
		ST_P_CMP,
		ST_H_RD,
		ST_H_CMP,
		ST_SW2,
		ST_R_RD,
		ST_R_WA,
		ST_R_WB,
		ST_E_RD,
		ST_E_OUT,
		ST_EXH
	} lpg_state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_IDENT,
		OP_P_INIT,
		OP_P_RD,
		OP_P_CMP,
		OP_H_INIT,
		OP_H_RD,
		OP_H_CMP,
		OP_SW1,
		OP_SW2,
		OP_R_RD,
		OP_R_WA,
		OP_R_WB,
		OP_E_INIT,
		OP_E_RD,
		OP_E_OUT,
		OP_X_OUT
	} lpg_op_t;

	typedef struct packed {
		logic pair_ok;
		logic single_ok;
		logic found;
		logic rev_more;
		logic out_free;
		logic elem_last;
	} lpg_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/lexicographic_permutation_generator_top.sv
// top level of the lexicographic permutation generator
// a restart sets the permutation to the identity and streams it out beat by beat; an advance
// first scans for the pivot, then for the swap partner, swaps the two and reverses the
// suffix pair by pair, then streams out the result
// one request at a time: the controller takes a request only while idle, and a request
// after the last permutation gets a single exhausted beat. reset clears the controller,
// the output valid and the entry valid bits, so the permutation reads as the identity at
// once, and loads length 3
`timescale 1ns / 1ps
`default_nettype none

module lexicographic_permutation_generator_top #(
	parameter int MAX_LENGTH = lpg_pkg::LPG_MAX_LENGTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// request channel
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [lpg_pkg::LPG_TDATA_W-1:0]  s_axis_tdata,   // [0] restart, rest zero
	// result channel
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic      [lpg_pkg::LPG_TDATA_W-1:0]  m_axis_tdata,   // [3:0] element_value
	output logic                                  m_axis_tlast,   // last_of_permutation
	output logic                                  m_axis_tuser,   // [0] exhausted
	// length register
	input  wire logic                             cfg_we,
	input  wire logic [lpg_pkg::LPG_LEN_W-1:0]    cfg_wdata
);

	import lpg_pkg::*;

	lpg_op_t              op;
	lpg_status_t          status;
	logic [LPG_VAL_W-1:0] m_value;

	// controller: decides restart, advance or exhausted, and steps the datapath
	lpg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_restart (s_axis_tdata[0]),
		.in_ready   (s_axis_tready),
		.cfg_we     (cfg_we),
		.status     (status),
		.op         (op)
	);

	// datapath: permutation ram, scan indexes and the output beat register
	lpg_dpath #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.status    (status),
		.m_valid   (m_axis_tvalid),
		.m_ready   (m_axis_tready),
		.m_value   (m_value),
		.m_last    (m_axis_tlast),
		.m_exh     (m_axis_tuser)
	);

	// pad the value up to a whole byte
	assign m_axis_tdata = {{(LPG_TDATA_W - LPG_VAL_W){1'b0}}, m_value};

endmodule

`default_nettype wire

FILE: rtl/core/lpg_ram.sv
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps
`default_nettype none

module lpg_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 8
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [$clog2(DEPTH)-1:0]   waddr,
	input  wire logic [WIDTH-1:0]           wdata,
	input  wire logic                       re_a,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr_a,
	output logic      [WIDTH-1:0]           rdata_a,
	input  wire logic                       re_b,
	input  wire logic [$clog2(DEPTH)-1:0]   raddr_b,
	output logic      [WIDTH-1:0]           rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re_a) begin
			rdata_a <= mem_q[raddr_a];
		end
		if (re_b) begin
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/core/lpg_ctrl.sv
// sequencing state machine of the permutation generator
`timescale 1ns / 1ps
`default_nettype none

module lpg_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_restart,
	output logic                      in_ready,
	input  wire logic                 cfg_we,
	input  wire lpg_pkg::lpg_status_t status,
	output lpg_pkg::lpg_op_t          op
);

	import lpg_pkg::*;

	lpg_state_t state_q, state_d;
	logic       started_q;
	logic       finished_q;
	logic       accept;
	logic       fresh;

	assign accept = in_valid && (state_q == ST_IDLE);
	assign fresh  = in_restart || !started_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			started_q  <= 1'b0;
			finished_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				started_q  <= 1'b0;
				finished_q <= 1'b0;
			end else if (accept && fresh) begin
				started_q  <= 1'b1;
				finished_q <= 1'b0;
			end else if (state_q == ST_EXH) begin
				finished_q <= 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (fresh) state_d = ST_E_RD;
					else if (finished_q) state_d = ST_EXH;
					else state_d = ST_P_RD;
				end
			end
			ST_P_RD: begin
				if (status.pair_ok) state_d = ST_P_CMP;
				else if (status.found) state_d = ST_H_RD;
				else state_d = ST_EXH;
			end
			ST_P_CMP: state_d = ST_P_RD;
			ST_H_RD:  state_d = status.single_ok ? ST_H_CMP : ST_SW2;
			ST_H_CMP: state_d = ST_H_RD;
			ST_SW2:   state_d = ST_R_RD;
			ST_R_RD:  state_d = status.rev_more ? ST_R_WA : ST_E_RD;
			ST_R_WA:  state_d = ST_R_WB;
			ST_R_WB:  state_d = ST_R_RD;
			ST_E_RD: begin
				if (status.out_free) state_d = ST_E_OUT;
			end
			ST_E_OUT: state_d = status.elem_last ? ST_IDLE : ST_E_RD;
			ST_EXH: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		op       = OP_NONE;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (fresh) op = OP_IDENT;
					else if (!finished_q) op = OP_P_INIT;
				end
			end
			ST_P_RD: begin
				if (status.pair_ok) op = OP_P_RD;
				else if (status.found) op = OP_H_INIT;
			end
			ST_P_CMP: op = OP_P_CMP;
			ST_H_RD:  op = status.single_ok ? OP_H_RD : OP_SW1;
			ST_H_CMP: op = OP_H_CMP;
			ST_SW2:   op = OP_SW2;
			ST_R_RD:  op = status.rev_more ? OP_R_RD : OP_E_INIT;
			ST_R_WA:  op = OP_R_WA;
			ST_R_WB:  op = OP_R_WB;
			ST_E_RD: begin
				if (status.out_free) op = OP_E_RD;
			end
			ST_E_OUT: op = OP_E_OUT;
			ST_EXH: begin
				if (status.out_free) op = OP_X_OUT;
			end
			default: op = OP_NONE;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/lpg_dpath.sv
// permutation store, index registers and output register
`timescale 1ns / 1ps
`default_nettype none

module lpg_dpath #(
	parameter int MAX_LENGTH = lpg_pkg::LPG_MAX_LENGTH
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire lpg_pkg::lpg_op_t               op,
	input  wire logic                           cfg_we,
	input  wire logic [lpg_pkg::LPG_LEN_W-1:0]  cfg_wdata,
	output lpg_pkg::lpg_status_t                status,
	output logic                                m_valid,
	input  wire logic                           m_ready,
	output logic      [lpg_pkg::LPG_VAL_W-1:0]  m_value,
	output logic                                m_last,
	output logic                                m_exh
);

	import lpg_pkg::*;

	localparam int IW = $clog2(MAX_LENGTH);
	localparam int CW = $clog2(MAX_LENGTH + 1);
	localparam int VW = CW;

	logic [LPG_LEN_W-1:0] len_q;
	logic [CW-1:0]        eff_len;
	logic [CW-1:0]        len_m1;
	logic [MAX_LENGTH-1:0] vld_q;
	logic                 found_q;
	logic [CW-1:0]        j_q;
	logic [CW-1:0]        j_inc;
	logic [IW-1:0]        piv_q, hi_q, lo_q, rhi_q;
	logic [VW-1:0]        pivval_q, hival_q;
	logic                 rda_vld_q, rdb_vld_q;
	logic [IW-1:0]        rda_idx_q, rdb_idx_q;
	logic [VW-1:0]        rdata_a, rdata_b, val_a, val_b;
	logic                 we, re_a, re_b;
	logic [IW-1:0]        waddr, raddr_a, raddr_b;
	logic [VW-1:0]        wdata;
	logic [VW+LPG_VAL_W-1:0] val_wide;

	// the effective length saturates the length register into 1..MAX_LENGTH
	always_comb begin
		if (len_q == '0) eff_len = CW'(1);
		else if (int'(len_q) > MAX_LENGTH) eff_len = CW'(MAX_LENGTH);
		else eff_len = CW'(len_q);
	end

	assign len_m1 = eff_len - CW'(1);
	assign j_inc  = j_q + CW'(1);

	// entries never written since the last restart read as the identity
	assign val_a = rda_vld_q ? rdata_a : VW'(rda_idx_q) + VW'(1);
	assign val_b = rdb_vld_q ? rdata_b : VW'(rdb_idx_q) + VW'(1);
	assign val_wide = {{LPG_VAL_W{1'b0}}, val_a};

	assign status.pair_ok   = j_inc < eff_len;
	assign status.single_ok = j_q < eff_len;
	assign status.found     = found_q;
	assign status.rev_more  = lo_q < rhi_q;
	assign status.out_free  = !m_valid || m_ready;
	assign status.elem_last = j_inc == eff_len;

	always_comb begin
		we      = 1'b0;
		waddr   = piv_q;
		wdata   = hival_q;
		re_a    = 1'b0;
		re_b    = 1'b0;
		raddr_a = j_q[IW-1:0];
		raddr_b = j_inc[IW-1:0];
		unique case (op) inside
			OP_P_RD: begin
				re_a = 1'b1;
				re_b = 1'b1;
			end
			OP_H_RD, OP_E_RD: re_a = 1'b1;
			OP_R_RD: begin
				re_a    = 1'b1;
				re_b    = 1'b1;
				raddr_a = lo_q;
				raddr_b = rhi_q;
			end
			OP_SW1: we = 1'b1;
			OP_SW2: begin
				we    = 1'b1;
				waddr = hi_q;
				wdata = pivval_q;
			end
			OP_R_WA: begin
				we    = 1'b1;
				waddr = lo_q;
				wdata = val_b;
			end
			OP_R_WB: begin
				we    = 1'b1;
				waddr = rhi_q;
				wdata = val_a;
			end
			default: ;
		endcase
	end

	lpg_ram #(
		.WIDTH (VW),
		.DEPTH (MAX_LENGTH)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.re_a    (re_a),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a),
		.re_b    (re_b),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b)
	);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= LPG_LEN_RESET;
			vld_q   <= '0;
			found_q <= 1'b0;
			m_valid <= 1'b0;
		end else begin
			if (cfg_we) len_q <= cfg_wdata;
			if (op == OP_IDENT) vld_q <= '0;
			else if (we) vld_q[waddr] <= 1'b1;
			if (op == OP_P_INIT) found_q <= 1'b0;
			else if (op == OP_P_CMP && val_a < val_b) found_q <= 1'b1;
			if (op == OP_E_OUT || op == OP_X_OUT) m_valid <= 1'b1;
			else if (m_ready) m_valid <= 1'b0;
		end
	end

	// indexes and held values
	always_ff @(posedge clk) begin
		if (re_a) begin
			rda_vld_q <= vld_q[raddr_a];
			rda_idx_q <= raddr_a;
		end
		if (re_b) begin
			rdb_vld_q <= vld_q[raddr_b];
			rdb_idx_q <= raddr_b;
		end
		unique case (op) inside
			OP_IDENT, OP_P_INIT, OP_E_INIT: j_q <= '0;
			OP_P_CMP: begin
				if (val_a < val_b) begin
					piv_q    <= j_q[IW-1:0];
					pivval_q <= val_a;
				end
				j_q <= j_inc;
			end
			OP_H_INIT: j_q <= CW'(piv_q) + CW'(1);
			OP_H_CMP: begin
				if (val_a > pivval_q) begin
					hi_q    <= j_q[IW-1:0];
					hival_q <= val_a;
				end
				j_q <= j_inc;
			end
			OP_SW2: begin
				lo_q  <= piv_q + IW'(1);
				rhi_q <= len_m1[IW-1:0];
			end
			OP_R_WB: begin
				lo_q  <= lo_q + IW'(1);
				rhi_q <= rhi_q - IW'(1);
			end
			OP_E_OUT: begin
				m_value <= val_wide[LPG_VAL_W-1:0];
				m_last  <= status.elem_last;
				m_exh   <= 1'b0;
				j_q     <= j_inc;
			end
			OP_X_OUT: begin
				m_value <= '0;
				m_last  <= 1'b1;
				m_exh   <= 1'b1;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/core/lpg_checker.sv
// port level checks of the permutation generator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module lpg_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic       m_axis_tlast,
	input wire logic       m_axis_tuser
);

	// an exhausted beat is a lone zero beat closing the run
	a_exh_shape: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'd0))
		else $error("exhausted beat malformed");

	// one request at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while busy");

	// no request accepted in the middle of a permutation
	a_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> !s_axis_tready)
		else $error("request accepted mid permutation");

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tlast) && $stable(m_axis_tuser))
		else $error("stalled beat changed");

endmodule

bind lexicographic_permutation_generator_top lpg_checker u_lpg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
